FILE: hdl/qpnd_pkg.sv
// Package for the quoted-printable name decoder.
// Holds the escape constants, the command word passed from front to back and the hex decode.
// No dependencies.
package qpnd_pkg;

  localparam logic [7:0] EscByte = 8'h3d;
  localparam int unsigned HexBase = 16;
  localparam int unsigned CmdQueueDepth = 4;
  localparam int unsigned MaxCmdBytes = 3;

  // One command: up to three bytes to emit, oldest in slot 0.
  typedef struct packed {
    logic [1:0]       n;
    logic             last;
    logic [2:0][7:0]  bytes;
  } qpnd_cmd_t;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_EQ     = 3'b010,
    PH_HEX    = 3'b100
  } qpnd_phase_e;

  typedef struct packed {
    logic valid;
    logic [3:0] value;
  } qpnd_hex_t;

  function automatic qpnd_hex_t hex_value(input logic [7:0] c);
    qpnd_hex_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/quoted_printable_name_decoder_unit.sv
// Top level of the quoted-printable name decoder.
// Instantiates qpnd_front, qpnd_cmd_fifo and qpnd_back; depends on qpnd_pkg.
//
//  Channel  | Handshake          | Words
//  ---------+--------------------+----------------------------------
//  input    | push / full        | data_byte_i[7:0], name_end_i
//  result   | pop / empty        | out_byte_o[7:0], out_last_o
//
// The front takes one input word per cycle while the command queue has room.
// The back delivers one result word per cycle while pop is high and empty is
// low; a command of up to three bytes holds it until all are popped, and the
// queue depth sets how long a burst of such commands is absorbed before full
// rises. A result waits behind older commands. rst_ni clears the escape
// phase, the held hex digit and the queue at once; no warm-up is needed.
module quoted_printable_name_decoder_unit #(
  parameter int unsigned CmdDepth = qpnd_pkg::CmdQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       name_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import qpnd_pkg::*;

  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  qpnd_cmd_t       cmd, head;
  logic            cmd_push, q_full, head_valid, head_pop;
  logic [CntW-1:0] q_count;

  qpnd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .data_byte_i (data_byte_i),
    .name_end_i  (name_end_i),
    .q_full_i    (q_full),
    .full        (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd)
  );

  qpnd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (cmd_push),
    .wr_data_i   (cmd),
    .rd_i        (head_pop),
    .rd_data_o   (head),
    .not_empty_o (head_valid),
    .full_o      (q_full),
    .count_o     (q_count)
  );

  qpnd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

  // The final byte of a name always produces a command marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && name_end_i) |-> (cmd_push && cmd.last))
    else $error("name end did not produce a last command");

  // Queued commands never carry zero bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (cmd.n != 2'd0))
    else $error("empty command pushed");

  // The queue count stays within its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(CmdDepth))
    else $error("command queue overflow");

  // A queue entry that is ever shown as head must not be popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> (head_valid && !empty))
    else $error("head popped from empty queue");

endmodule

FILE: hdl/qpnd_front.sv
// Front part of the decoder: accepts raw bytes, tracks the escape phase
// and turns each byte into at most one command word. Depends on qpnd_pkg.
module qpnd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic [7:0]          data_byte_i,
  input  logic                name_end_i,
  input  logic                q_full_i,
  output logic                full,
  output logic                cmd_push_o,
  output qpnd_pkg::qpnd_cmd_t cmd_o
);
  import qpnd_pkg::*;

  qpnd_phase_e phase_q, phase_d;
  logic [7:0]  first_hex_q, first_hex_d;
  qpnd_hex_t   hv, hi;
  qpnd_cmd_t   cmd;
  logic        accept;

  function automatic qpnd_cmd_t add_byte(input qpnd_cmd_t c, input logic [7:0] b);
    qpnd_cmd_t r;
    r = c;
    case (c.n)
      2'd0:    r.bytes[0] = b;
      2'd1:    r.bytes[1] = b;
      default: r.bytes[2] = b;
    endcase
    r.n = c.n + 2'd1;
    return r;
  endfunction

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign hv     = hex_value(data_byte_i);
  assign hi     = hex_value(first_hex_q);

  always_comb begin
    cmd         = '0;
    phase_d     = PH_NORMAL;
    first_hex_d = first_hex_q;
    case (phase_q)
      PH_EQ: begin
        if (data_byte_i == EscByte) begin
          cmd     = add_byte(cmd, EscByte);
          phase_d = PH_EQ;
        end else if (hv.valid) begin
          first_hex_d = data_byte_i;
          phase_d     = PH_HEX;
        end else begin
          cmd = add_byte(cmd, EscByte);
          cmd = add_byte(cmd, data_byte_i);
        end
      end
      PH_HEX: begin
        if (data_byte_i == EscByte) begin
          cmd     = add_byte(cmd, EscByte);
          cmd     = add_byte(cmd, first_hex_q);
          phase_d = PH_EQ;
        end else if (hv.valid) begin
          cmd = add_byte(cmd, {hi.value, hv.value});
        end else begin
          cmd = add_byte(cmd, EscByte);
          cmd = add_byte(cmd, first_hex_q);
          cmd = add_byte(cmd, data_byte_i);
        end
      end
      default: begin
        if (data_byte_i == EscByte) begin
          phase_d = PH_EQ;
        end else begin
          cmd = add_byte(cmd, data_byte_i);
        end
      end
    endcase

    // At the end of a name every held-back byte is released literally.
    if (name_end_i) begin
      if (phase_d == PH_EQ) begin
        cmd = add_byte(cmd, EscByte);
      end else if (phase_d == PH_HEX) begin
        cmd = add_byte(cmd, EscByte);
        cmd = add_byte(cmd, first_hex_d);
      end
      cmd.last    = 1'b1;
      phase_d     = PH_NORMAL;
      first_hex_d = 8'd0;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept && (cmd.n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NORMAL;
      first_hex_q <= 8'd0;
    end else if (accept) begin
      phase_q     <= phase_d;
      first_hex_q <= first_hex_d;
    end
  end

endmodule

FILE: hdl/qpnd_cmd_fifo.sv
// Short command queue between the front and back parts of the decoder.
// Register-based circular buffer. Depends on qpnd_pkg.
module qpnd_cmd_fifo #(
  parameter int unsigned Depth = qpnd_pkg::CmdQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  qpnd_pkg::qpnd_cmd_t           wr_data_i,
  input  logic                          rd_i,
  output qpnd_pkg::qpnd_cmd_t           rd_data_o,
  output logic                          not_empty_o,
  output logic                          full_o,
  output logic [$clog2(Depth+1)-1:0]    count_o
);
  import qpnd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  qpnd_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign do_wr = wr_i && (cnt_q != FullCnt);
  assign do_rd = rd_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o   = mem_q[rd_ptr_q];
  assign not_empty_o = (cnt_q != '0);
  assign full_o      = (cnt_q == FullCnt);
  assign count_o     = cnt_q;

endmodule

FILE: hdl/qpnd_back.sv
// Back part of the decoder: steps through the bytes of the oldest command
// and presents them one word at a time on the result side. Depends on qpnd_pkg.
module qpnd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  qpnd_pkg::qpnd_cmd_t head_i,
  output logic                head_pop_o,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);
  import qpnd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       take, at_end;

  assign empty  = !head_valid_i;
  assign take   = pop && head_valid_i;
  assign at_end = (idx_q == head_i.n - 2'd1);

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = head_i.bytes[0];
      2'd1:    out_byte_o = head_i.bytes[1];
      default: out_byte_o = head_i.bytes[2];
    endcase
  end

  assign out_last_o = head_i.last && at_end;
  assign head_pop_o = take && at_end;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
